### rtl/vsrs_pkg.sv
package vsrs_pkg;

    localparam int unsigned ATTEMPT_LIMIT = 15;

    localparam logic [6:0]  SPEED_RESET   = 7'd50;
    localparam logic [6:0]  SPEED_MAX     = 7'd100;
    localparam logic [15:0] SAMPLE_RESET  = 16'd300;
    localparam logic [15:0] BACKOFF_RESET = 16'd200;
    localparam logic [15:0] FINAL_RESET   = 16'd400;

    localparam logic [1:0]  PORT_MAX      = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_FORWARD = 2'd1,
        PH_BACKOFF = 2'd2,
        PH_FINAL   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        CFG_MOTOR_SPEED   = 2'd0,
        CFG_SAMPLE_TICKS  = 2'd1,
        CFG_BACKOFF_TICKS = 2'd2,
        CFG_FINAL_TICKS   = 2'd3
    } cfg_index_t;

    typedef enum logic {
        CMD_TICK  = 1'b0,
        CMD_START = 1'b1
    } cmd_t;

    typedef struct packed {
        logic               cmd;
        logic               close_valve;
        logic [3:0]         attempt_count;
        logic [1:0]         motor_port;
        logic signed [15:0] encoder_position;
    } cmd_item_t;

    typedef struct packed {
        logic signed [7:0] motor_drive;
        logic [1:0]        drive_port;
        logic              busy_res;
        logic              done_res;
    } res_item_t;

endpackage

### rtl/valve_stall_retry_sequencer_top.sv
// Valve stall-and-retry sequencer for one motor. Every accepted item (a 1 ms tick or a
// start) yields exactly one result item with the drive now applied, its port, busy and a
// done pulse. The item is processed combinationally: it updates the sequencer state and
// loads the result register on the same edge, so the block takes one item per clock and
// keeps taking items while the result register is full as long as the result is taken in
// that cycle (cmd_stall follows res_valid and res_stall). A start seen while busy, or one
// naming port 3, is ignored and only reports the current status. Configuration writes
// take effect on the next item.
module valve_stall_retry_sequencer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_stall,
    input  vsrs_pkg::cmd_item_t  cmd_item,
    output logic                 res_valid,
    input  logic                 res_stall,
    output vsrs_pkg::res_item_t  res_item,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);
    import vsrs_pkg::*;

    logic [6:0]  speed_reg;
    logic [15:0] sample_reg;
    logic [15:0] backoff_reg;
    logic [15:0] final_reg;

    phase_t      phase_reg, phase_next;
    logic [3:0]  attempts_done_reg, attempts_done_next;
    logic [3:0]  attempts_goal_reg, attempts_goal_next;
    logic [15:0] tick_timer_reg, tick_timer_next;
    logic [15:0] last_position_reg, last_position_next;
    logic        closing_reg, closing_next;
    logic [1:0]  active_port_reg, active_port_next;

    logic        res_valid_reg;
    res_item_t   res_item_reg, res_item_next;

    logic        accept;
    logic [16:0] timer_inc;
    logic [15:0] period;
    logic        period_end;
    logic [3:0]  start_count;
    logic [3:0]  done_inc;
    logic [6:0]  speed_sat;
    logic signed [7:0] fwd_drive;
    logic        done_flag;

    assign cmd_stall = res_valid_reg && res_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg   <= SPEED_RESET;
            sample_reg  <= SAMPLE_RESET;
            backoff_reg <= BACKOFF_RESET;
            final_reg   <= FINAL_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MOTOR_SPEED:   speed_reg   <= cfg_data[6:0];
                CFG_SAMPLE_TICKS:  sample_reg  <= cfg_data;
                CFG_BACKOFF_TICKS: backoff_reg <= cfg_data;
                CFG_FINAL_TICKS:   final_reg   <= cfg_data;
                default:           speed_reg   <= speed_reg;
            endcase
        end
    end

    always_comb
    begin
        period = final_reg;
        if (phase_reg == PH_FORWARD)
        begin
            period = sample_reg;
        end
        else if (phase_reg == PH_BACKOFF)
        begin
            period = backoff_reg;
        end
    end

    assign timer_inc  = {1'b0, tick_timer_reg} + 17'd1;
    assign period_end = timer_inc >= {1'b0, period};
    assign done_inc   = attempts_done_reg + 4'd1;

    assign start_count = ({4'd0, cmd_item.attempt_count} > 8'(ATTEMPT_LIMIT))
                         ? 4'(ATTEMPT_LIMIT) : cmd_item.attempt_count;

    always_comb
    begin
        phase_next         = phase_reg;
        attempts_done_next = attempts_done_reg;
        attempts_goal_next = attempts_goal_reg;
        tick_timer_next    = tick_timer_reg;
        last_position_next = last_position_reg;
        closing_next       = closing_reg;
        active_port_next   = active_port_reg;
        done_flag          = 1'b0;

        if (cmd_item.cmd == CMD_START)
        begin
            if (phase_reg == PH_IDLE && cmd_item.motor_port <= PORT_MAX)
            begin
                closing_next       = cmd_item.close_valve;
                active_port_next   = cmd_item.motor_port;
                attempts_goal_next = start_count;
                attempts_done_next = 4'd0;
                tick_timer_next    = 16'd0;
                last_position_next = cmd_item.encoder_position;
                phase_next         = (start_count == 4'd0) ? PH_FINAL : PH_FORWARD;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_FORWARD:
                begin
                    if (period_end)
                    begin
                        tick_timer_next    = 16'd0;
                        last_position_next = cmd_item.encoder_position;
                        if (cmd_item.encoder_position == last_position_reg)
                        begin
                            phase_next = PH_BACKOFF;
                        end
                    end
                    else
                    begin
                        tick_timer_next = timer_inc[15:0];
                    end
                end
                PH_BACKOFF:
                begin
                    if (period_end)
                    begin
                        tick_timer_next    = 16'd0;
                        attempts_done_next = done_inc;
                        if (done_inc >= attempts_goal_reg)
                        begin
                            phase_next = PH_FINAL;
                        end
                        else
                        begin
                            phase_next         = PH_FORWARD;
                            last_position_next = cmd_item.encoder_position;
                        end
                    end
                    else
                    begin
                        tick_timer_next = timer_inc[15:0];
                    end
                end
                PH_FINAL:
                begin
                    if (period_end)
                    begin
                        tick_timer_next = 16'd0;
                        phase_next      = PH_IDLE;
                        done_flag       = 1'b1;
                    end
                    else
                    begin
                        tick_timer_next = timer_inc[15:0];
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // result from the updated state
    assign speed_sat = (speed_reg > SPEED_MAX) ? SPEED_MAX : speed_reg;
    assign fwd_drive = closing_next ? $signed({1'b0, speed_sat})
                                    : -$signed({1'b0, speed_sat});

    always_comb
    begin
        res_item_next.motor_drive = 8'sd0;
        if (phase_next == PH_FORWARD || phase_next == PH_FINAL)
        begin
            res_item_next.motor_drive = fwd_drive;
        end
        else if (phase_next == PH_BACKOFF)
        begin
            res_item_next.motor_drive = -fwd_drive;
        end
        res_item_next.drive_port = active_port_next;
        res_item_next.busy_res   = (phase_next != PH_IDLE);
        res_item_next.done_res   = done_flag;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            attempts_done_reg <= 4'd0;
            attempts_goal_reg <= 4'd0;
            tick_timer_reg    <= 16'd0;
            last_position_reg <= 16'd0;
            closing_reg       <= 1'b0;
            active_port_reg   <= 2'd0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg         <= phase_next;
                attempts_done_reg <= attempts_done_next;
                attempts_goal_reg <= attempts_goal_next;
                tick_timer_reg    <= tick_timer_next;
                last_position_reg <= last_position_next;
                closing_reg       <= closing_next;
                active_port_reg   <= active_port_next;
                res_valid_reg     <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_item_reg <= res_item_next;
        end
    end

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_item.done_res |-> !res_item.busy_res)
        else $error("done pulsed while still busy");

    a_idle_timer_clear: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> tick_timer_reg == 16'd0)
        else $error("tick timer running while idle");

    a_attempts_bound: assert property (@(posedge clk) disable iff (!rst_n)
        attempts_done_reg <= attempts_goal_reg)
        else $error("attempts done beyond goal");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> res_valid)
        else $error("accepted item produced no result");

endmodule

### bench/valve_stall_retry_sequencer_top_tb.sv
module valve_stall_retry_sequencer_top_tb;
    import vsrs_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 50;

    logic clk;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_item_t cmd_item = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_item_t res_item;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    valve_stall_retry_sequencer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // register copies
    logic [6:0] speed_reg = SPEED_RESET;
    logic [15:0] sample_len = SAMPLE_RESET;
    logic [15:0] backoff_len = BACKOFF_RESET;
    logic [15:0] final_len = FINAL_RESET;

    // sequencer copy
    phase_t vs_phase = PH_IDLE;
    logic [3:0] vs_done_cnt = '0;
    logic [3:0] vs_goal = '0;
    logic [15:0] vs_timer = '0;
    logic [15:0] vs_last = '0;
    logic vs_closing = 1'b0;
    logic [1:0] vs_port = '0;

    cmd_item_t pending_q[$];
    res_item_t expected_q[$];

    bit jitter = 1'b1;
    bit squeeze_req = 1'b0;
    int send_gap = 0;
    int hold_left = 0;
    int queued = 0;
    int items_sent = 0;
    int results_seen = 0;
    int ops_done = 0;
    int held_cycles = 0;
    int faults = 0;
    int cycle_count = 0;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int pick_gap();
        if ($urandom_range(9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int stretch(logic [15:0] d);
        return (d == 0) ? 1 : int'(d);
    endfunction

    function automatic bit span_over(logic [15:0] d);
        return ({1'b0, vs_timer} + 17'd1) >= {1'b0, d};
    endfunction

    function automatic res_item_t step_valve(cmd_item_t it);
        res_item_t r;
        logic [6:0] mag;
        logic signed [7:0] push;
        logic stop;
        stop = 1'b0;
        if (it.cmd == CMD_START)
        begin
            if (vs_phase == PH_IDLE && it.motor_port <= PORT_MAX)
            begin
                vs_closing = it.close_valve;
                vs_port = it.motor_port;
                vs_goal = (it.attempt_count > ATTEMPT_LIMIT) ? 4'(ATTEMPT_LIMIT)
                                                             : it.attempt_count;
                vs_done_cnt = '0;
                vs_timer = '0;
                vs_last = it.encoder_position;
                vs_phase = (vs_goal == 0) ? PH_FINAL : PH_FORWARD;
            end
        end
        else
        begin
            case (vs_phase)
                PH_FORWARD:
                begin
                    if (span_over(sample_len))
                    begin
                        vs_timer = '0;
                        if (it.encoder_position == vs_last)
                            vs_phase = PH_BACKOFF;
                        vs_last = it.encoder_position;
                    end
                    else
                        vs_timer++;
                end
                PH_BACKOFF:
                begin
                    if (span_over(backoff_len))
                    begin
                        vs_timer = '0;
                        vs_done_cnt++;
                        if (vs_done_cnt >= vs_goal)
                            vs_phase = PH_FINAL;
                        else
                        begin
                            vs_phase = PH_FORWARD;
                            vs_last = it.encoder_position;
                        end
                    end
                    else
                        vs_timer++;
                end
                PH_FINAL:
                begin
                    if (span_over(final_len))
                    begin
                        vs_timer = '0;
                        vs_phase = PH_IDLE;
                        stop = 1'b1;
                    end
                    else
                        vs_timer++;
                end
                default: ;
            endcase
        end
        mag = (speed_reg > SPEED_MAX) ? SPEED_MAX : speed_reg;
        push = vs_closing ? $signed({1'b0, mag}) : -$signed({1'b0, mag});
        case (vs_phase)
            PH_FORWARD, PH_FINAL: r.motor_drive = push;
            PH_BACKOFF: r.motor_drive = -push;
            default: r.motor_drive = '0;
        endcase
        r.drive_port = vs_port;
        r.busy_res = (vs_phase != PH_IDLE);
        r.done_res = stop;
        return r;
    endfunction

    function automatic void queue_tick(logic [15:0] pos);
        cmd_item_t it;
        it = cmd_item_t'(24'($urandom));
        it.cmd = CMD_TICK;
        it.encoder_position = pos;
        pending_q.push_back(it);
        queued++;
    endfunction

    function automatic void queue_start(logic close, logic [3:0] n, logic [1:0] port,
                                        logic [15:0] pos);
        cmd_item_t it;
        it.cmd = CMD_START;
        it.close_valve = close;
        it.attempt_count = n;
        it.motor_port = port;
        it.encoder_position = pos;
        pending_q.push_back(it);
        queued++;
    endfunction

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                expected_q.push_back(step_valve(cmd_item));
                void'(pending_q.pop_front());
                items_sent++;
                send_gap = (jitter && $urandom_range(99) < 30) ? pick_gap() : 0;
            end
            if (cmd_valid && cmd_stall)
                held_cycles++;
            else if (send_gap != 0)
            begin
                send_gap--;
                cmd_valid <= 1'b0;
            end
            else if (pending_q.size() != 0)
            begin
                cmd_item <= pending_q[0];
                cmd_valid <= 1'b1;
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (hold_left != 0)
            hold_left--;
        else if (squeeze_req)
        begin
            hold_left = 150;
            squeeze_req = 1'b0;
        end
        else if (jitter && $urandom_range(99) < 20)
            hold_left = pick_gap();
        res_stall <= (hold_left != 0);
    end

    // result checker
    always @(posedge clk)
    begin
        res_item_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                if (faults < 10)
                    $display("result %0d arrived with nothing pending", results_seen);
                faults++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (want.done_res)
                    ops_done++;
                if (res_item.motor_drive !== want.motor_drive
                    || res_item.drive_port !== want.drive_port
                    || res_item.busy_res !== want.busy_res
                    || res_item.done_res !== want.done_res)
                begin
                    if (faults < 10)
                        $display({"result %0d: want drive %0d port %0d busy %0b done %0b,",
                                  " got drive %0d port %0d busy %0b done %0b"},
                                 results_seen, want.motor_drive, want.drive_port,
                                 want.busy_res, want.done_res, res_item.motor_drive,
                                 res_item.drive_port, res_item.busy_res, res_item.done_res);
                    faults++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timed out after %0d cycles, %0d results still pending",
                     cycle_count, expected_q.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_MOTOR_SPEED: speed_reg = val[6:0];
            CFG_SAMPLE_TICKS: sample_len = val;
            CFG_BACKOFF_TICKS: backoff_len = val;
            CFG_FINAL_TICKS: final_len = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [6:0] speed, logic [15:0] smp, logic [15:0] bko,
                              logic [15:0] fin);
        write_reg(CFG_MOTOR_SPEED, {9'($urandom), speed});
        write_reg(CFG_SAMPLE_TICKS, smp);
        write_reg(CFG_BACKOFF_TICKS, bko);
        write_reg(CFG_FINAL_TICKS, fin);
    endtask

    task automatic settle();
        while (pending_q.size() != 0 || expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // run held-encoder ticks until the sequencer goes idle
    task automatic finish_ops();
        logic [15:0] hold_pos;
        int chunk;
        settle();
        while (vs_phase != PH_IDLE)
        begin
            hold_pos = 16'($urandom);
            chunk = (int'(vs_goal) - int'(vs_done_cnt) + 1)
                    * (stretch(sample_len) + stretch(backoff_len))
                    + stretch(final_len) + 2;
            repeat (chunk) queue_tick(hold_pos);
            settle();
        end
    endtask

    task automatic random_operation();
        logic [3:0] n;
        logic [1:0] port;
        logic [15:0] pos;
        int span;
        int r;
        n = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        port = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        pos = 16'($urandom);
        queue_start(1'($urandom), n, port, pos);
        span = int'(n) * (stretch(sample_len) + stretch(backoff_len)) + stretch(final_len);
        repeat ($urandom_range(span + span / 2 + 2))
        begin
            r = $urandom_range(99);
            if (r < 4)
                queue_start(1'($urandom), 4'($urandom), 2'($urandom), 16'($urandom));
            else
            begin
                if (r < 15)
                    pos = pos + 16'd1;
                else if (r < 30)
                    pos = 16'($urandom);
                queue_tick(pos);
            end
        end
    endtask

    initial
    begin
        int mark;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // short periods, speed left at its reset value
        write_reg(CFG_SAMPLE_TICKS, 16'd2);
        write_reg(CFG_BACKOFF_TICKS, 16'd1);
        write_reg(CFG_FINAL_TICKS, 16'd0);
        queue_tick(16'h8000);
        queue_start(1'b1, 4'd15, 2'd3, 16'h0000);
        queue_start(1'b1, 4'd0, 2'd2, 16'h7fff);
        queue_tick(16'h7fff);
        queue_tick(16'h0000);
        queue_start(1'b0, 4'd2, 2'd1, 16'h0000);
        queue_start(1'b1, 4'd9, 2'd0, 16'h5555);
        repeat (4) queue_tick(16'h0005);
        repeat (3) queue_tick(16'h0007);
        queue_tick(16'hffff);
        queue_tick(16'haaaa);
        queue_start(1'b1, 4'd15, 2'd0, 16'hffff);
        finish_ops();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0: set_config(7'd127, 16'd0, 16'd0, 16'd3);
                1: set_config(7'd100, 16'd1, 16'd2, 16'd1);
                2: set_config(7'd0, 16'd4, 16'd3, 16'd0);
                default: set_config(7'($urandom), 16'($urandom_range(6)),
                                    16'($urandom_range(6)), 16'($urandom_range(6)));
            endcase
            jitter = (ph % 3 != 2);
            if (ph == 4)
            begin
                jitter = 1'b0;
                squeeze_req = 1'b1;
            end
            mark = queued;
            while (queued - mark < PHASE_ITEMS)
                random_operation();
            finish_ops();
        end

        settle();
        repeat (8) @(posedge clk);
        $display("%0d items sent, %0d results checked, %0d operations completed",
                 items_sent, results_seen, ops_done);
        $display("%0d cycles with the input held off, %0d mismatches", held_cycles, faults);
        if (faults == 0 && expected_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

### filelist.f
rtl/vsrs_pkg.sv
rtl/valve_stall_retry_sequencer_top.sv
bench/valve_stall_retry_sequencer_top_tb.sv
